// ===== rtl/core/b64e_pkg.sv =====
// Shared types, constants and character mapping for the Base64 stream encoder.
// Used by b64e_enc, b64e_ser and base64_stream_encoder; depends on nothing else.
`default_nettype none

package b64e_pkg;

	localparam int unsigned CHAR_W    = 7;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned BURST_MAX = 8;
	localparam int unsigned BURST_CW  = $clog2(BURST_MAX + 1);

	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

	// Register map: word index decoded from paddr[2].
	localparam logic REG_SWAP_PAIRS = 1'b0;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last_char;
	} out_item_t;

	// Characters produced by one item, first character in entry 0.
	typedef struct packed {
		logic [BURST_MAX-1:0][CHAR_W-1:0] chars;
		logic [BURST_CW-1:0]              cnt;
		logic                             last;
	} burst_t;

	typedef struct packed {
		logic [1:0] group_count;
		logic       pair_phase;
	} enc_status_t;

	function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
		logic [CHAR_W-1:0] ch;
		case (idx) inside
			[6'd0:6'd25]:  ch = CHAR_W'(7'h41 + 7'(idx));
			[6'd26:6'd51]: ch = CHAR_W'(7'h61 + 7'(idx - 6'd26));
			[6'd52:6'd61]: ch = CHAR_W'(7'h30 + 7'(idx - 6'd52));
			6'd62:         ch = 7'h2B;
			default:       ch = 7'h2F;
		endcase
		return ch;
	endfunction

	// Splits three bytes into four characters; positions at or past nch are pads.
	function automatic logic [3:0][CHAR_W-1:0] enc_quad(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b,
		input logic [BYTE_W-1:0] c,
		input logic [2:0]        nch
	);
		logic [3:0][5:0]        idx;
		logic [3:0][CHAR_W-1:0] q;
		idx[0] = a[7:2];
		idx[1] = {a[1:0], b[7:4]};
		idx[2] = {b[3:0], c[7:6]};
		idx[3] = c[5:0];
		for (int k = 0; k < 4; k++) begin
			q[k] = (3'(k) < nch) ? b64_char(idx[k]) : PAD_CHAR;
		end
		return q;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64e_enc.sv =====
// Group and pair state of the encoder, the per-item character burst logic
// and the burst register (_s1). Depends on b64e_pkg.
`default_nettype none

module b64e_enc (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    swap_pairs,
	input  wire                    src_valid,
	output logic                   src_stall,
	input  b64e_pkg::in_item_t     src_item,
	input  wire                    s2_free,
	output b64e_pkg::burst_t       burst_s1,
	output logic                   burst_valid_s1,
	output b64e_pkg::enc_status_t  status
);
	import b64e_pkg::*;

	logic [1:0]        group_count_q;
	logic              pair_phase_q;
	logic [BYTE_W-1:0] group0_q;
	logic [BYTE_W-1:0] group1_q;
	logic [BYTE_W-1:0] held_byte_q;

	logic              src_acc;
	logic [1:0]        gc_nxt;
	logic [BYTE_W-1:0] g0_nxt;
	logic [BYTE_W-1:0] g1_nxt;
	logic              pp_nxt;
	logic              hold_now;
	burst_t            burst_nxt;

	assign src_stall = burst_valid_s1 && !s2_free;
	assign src_acc   = src_valid && !src_stall;
	assign status    = '{group_count: group_count_q, pair_phase: pair_phase_q};

	always_comb begin
		logic [1:0][BYTE_W-1:0] push_b;
		logic [1:0]             n_push;
		logic [2:0]             ci;
		logic [3:0][CHAR_W-1:0] q;
		push_b    = {held_byte_q, src_item.data_byte};
		gc_nxt    = group_count_q;
		g0_nxt    = group0_q;
		g1_nxt    = group1_q;
		burst_nxt = '0;
		hold_now  = 1'b0;
		pp_nxt    = 1'b0;
		q         = '0;
		ci        = '0;
		if (pair_phase_q) begin
			n_push = 2'd2;
		end else if (swap_pairs && !src_item.last_byte) begin
			n_push   = 2'd0;
			hold_now = 1'b1;
			pp_nxt   = 1'b1;
		end else begin
			n_push = 2'd1;
		end

		// At most two bytes enter the group per item: the new one, then a held one.
		for (int p = 0; p < 2; p++) begin
			if (2'(p) < n_push) begin
				if (gc_nxt == 2'd2) begin
					q  = enc_quad(g0_nxt, g1_nxt, push_b[p], 3'd4);
					ci = burst_nxt.cnt[2:0];
					for (int k = 0; k < 4; k++) begin
						burst_nxt.chars[ci + 3'(k)] = q[k];
					end
					burst_nxt.cnt = burst_nxt.cnt + BURST_CW'(4);
					gc_nxt = 2'd0;
				end else if (gc_nxt == 2'd0) begin
					g0_nxt = push_b[p];
					gc_nxt = 2'd1;
				end else begin
					g1_nxt = push_b[p];
					gc_nxt = 2'd2;
				end
			end
		end

		if (src_item.last_byte) begin
			if (gc_nxt != 2'd0) begin
				q  = enc_quad(g0_nxt, (gc_nxt == 2'd2) ? g1_nxt : '0, '0,
					(gc_nxt == 2'd2) ? 3'd3 : 3'd2);
				ci = burst_nxt.cnt[2:0];
				for (int k = 0; k < 4; k++) begin
					burst_nxt.chars[ci + 3'(k)] = q[k];
				end
				burst_nxt.cnt = burst_nxt.cnt + BURST_CW'(4);
			end
			gc_nxt = 2'd0;
			pp_nxt = 1'b0;
		end
		burst_nxt.last = src_item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q  <= '0;
			pair_phase_q   <= 1'b0;
			burst_valid_s1 <= 1'b0;
		end else begin
			if (src_acc && burst_nxt.cnt != '0) begin
				burst_valid_s1 <= 1'b1;
			end else if (s2_free) begin
				burst_valid_s1 <= 1'b0;
			end
			if (src_acc) begin
				group_count_q <= gc_nxt;
				pair_phase_q  <= pp_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) begin
			group0_q <= g0_nxt;
			group1_q <= g1_nxt;
			if (hold_now) begin
				held_byte_q <= src_item.data_byte;
			end
			if (burst_nxt.cnt != '0) begin
				burst_s1 <= burst_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/b64e_ser.sv =====
// Output stage (_s2): takes one character burst and shifts it out one
// character per accepted result item. Depends on b64e_pkg.
`default_nettype none

module b64e_ser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  b64e_pkg::burst_t    burst_s1,
	input  wire                 burst_valid_s1,
	output logic                s2_free,
	output logic                dst_valid,
	input  wire                 dst_stall,
	output b64e_pkg::out_item_t dst_item
);
	import b64e_pkg::*;

	logic [BURST_MAX-1:0][CHAR_W-1:0] chars_s2;
	logic [BURST_CW-1:0]              cnt_s2;
	logic                             last_s2;
	logic                             dst_acc;

	assign dst_valid          = (cnt_s2 != '0);
	assign dst_acc            = dst_valid && !dst_stall;
	assign s2_free            = !dst_valid || (dst_acc && cnt_s2 == BURST_CW'(1));
	assign dst_item.out_char  = chars_s2[0];
	assign dst_item.last_char = last_s2 && (cnt_s2 == BURST_CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (s2_free && burst_valid_s1) begin
			cnt_s2 <= burst_s1.cnt;
		end else if (dst_acc) begin
			cnt_s2 <= cnt_s2 - BURST_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && burst_valid_s1) begin
			chars_s2 <= burst_s1.chars;
			last_s2  <= burst_s1.last;
		end else if (dst_acc) begin
			chars_s2 <= chars_s2 >> CHAR_W;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_encoder.sv =====
// Top level of the Base64 stream encoder: APB register, encoder and output stage.
// Depends on b64e_pkg, b64e_enc and b64e_ser.
`default_nettype none

// The encoder takes one message byte per item on the src channel and streams
// standard Base64 characters (the 64-character alphabet plus '=' padding) on the
// dst channel, one character per item. Every three bytes yield four characters;
// an item with last_byte set flushes a partial group as two or three characters
// followed by '=' pads, and last_char marks the final character of the message.
// With swap_pairs set (register 0, bit 0, at byte address 0) each adjacent byte
// pair is exchanged before grouping; a final byte that arrives with no pair open
// is encoded as it is. Change swap_pairs only between messages while the block
// is idle. Each burst passes the burst register (_s1) and output stage (_s2)
// before its first character shows on dst. The encoder can take a byte and the
// output stage send one character every cycle, each unless stalled, so a long
// message sustains four characters per three bytes, a pace set by the output
// stage. One full burst of up to eight characters waits in the burst register
// while the output stage drains the one before; src stalls only while that
// register is full and the output stage has not yet taken its last character.
module base64_stream_encoder (
	input  wire                 clk,
	input  wire                 arst_n,
	// APB configuration port
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Input bytes
	input  wire                 src_valid,
	output logic                src_stall,
	input  b64e_pkg::in_item_t  src_item,
	// Output characters
	output logic                dst_valid,
	input  wire                 dst_stall,
	output b64e_pkg::out_item_t dst_item
);
	import b64e_pkg::*;

	logic        swap_pairs_q;
	logic        s2_free;
	burst_t      burst_s1;
	logic        burst_valid_s1;
	enc_status_t enc_status;

	// Configuration register. Only word 0 exists; other words read as zero.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SWAP_PAIRS) ? {31'd0, swap_pairs_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_pairs_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SWAP_PAIRS) begin
			swap_pairs_q <= pwdata[0];
		end
	end

	// Group and pair state; computes each item's burst in a single pass.
	b64e_enc u_enc (
		.clk            (clk),
		.arst_n         (arst_n),
		.swap_pairs     (swap_pairs_q),
		.src_valid      (src_valid),
		.src_stall      (src_stall),
		.src_item       (src_item),
		.s2_free        (s2_free),
		.burst_s1       (burst_s1),
		.burst_valid_s1 (burst_valid_s1),
		.status         (enc_status)
	);

	// Serializes bursts into single characters.
	b64e_ser u_ser (
		.clk            (clk),
		.arst_n         (arst_n),
		.burst_s1       (burst_s1),
		.burst_valid_s1 (burst_valid_s1),
		.s2_free        (s2_free),
		.dst_valid      (dst_valid),
		.dst_stall      (dst_stall),
		.dst_item       (dst_item)
	);

	// Every burst holds whole groups of four characters, one or two of them.
	assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid_s1 |-> (burst_s1.cnt == BURST_CW'(4) || burst_s1.cnt == BURST_CW'(8)))
		else $error("burst length is not four or eight characters");

	// A final byte always leaves the group empty and no pair open.
	assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall && src_item.last_byte)
		|=> (enc_status.group_count == 2'd0 && !enc_status.pair_phase))
		else $error("state not cleared after final byte");

	// The open group never holds three bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		enc_status.group_count != 2'd3)
		else $error("group count out of range");

	// A waiting burst keeps the input stalled until the output stage frees up.
	assert property (@(posedge clk) disable iff (!arst_n)
		(burst_valid_s1 && !s2_free) |-> (src_stall && dst_valid))
		else $error("input taken while burst register is occupied");

endmodule

`default_nettype wire
